// File: src/arp_pkg.sv
`default_nettype none

package arp_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int LEN_W = 11;
    localparam int OP_W  = 16;

    typedef logic [IP_W-1:0]  ip_t;
    typedef logic [MAC_W-1:0] mac_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [OP_W-1:0]  opcode_t;

    // One table slot as it is kept in the entry memory.
    typedef struct packed {
        ip_t  ip;
        mac_t mac;
    } entry_t;

    // Values of the action input.
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Shortest ARP payload that is processed.
    localparam len_t MIN_ARP_LEN = len_t'(28);

    // ARP opcode of a request.
    localparam opcode_t OP_REQUEST = opcode_t'(1);

endpackage

`default_nettype wire

// File: src/arp_cache_learn_and_reply.sv
`default_nettype none

// ARP cache with learning and reply detection. The block accepts one item
// (a received ARP packet or a lookup) when start is high and busy is low,
// and answers every item with exactly one result, marked by a one-cycle
// done pulse; the receiver cannot stall, so the result ports must be
// sampled in that cycle. The IP/MAC pairs live in a single-port-read,
// single-port-write memory of ENTRIES words with a registered read port;
// only the valid bits are flip-flops, and reset clears them at once, so no
// clearing pass is needed. An item walks the memory one slot per cycle,
// from the lowest slot up, and stops at the first qualifying slot; the
// read data is registered before it is compared. A packet shorter than
// 28 bytes is answered in the cycle after it is accepted. A pair is
// written back in the same cycle that its result is registered; the
// next item issues its first read only after it is accepted, so reads
// never overlap a pending write. The own_ip register is written through
// the cfg channel, which is ready whenever the block is idle.
module arp_cache_learn_and_reply #(
    parameter int ENTRIES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Item transfer.
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             action,
    input  wire arp_pkg::len_t    packet_length,
    input  wire arp_pkg::opcode_t arp_operation,
    input  wire arp_pkg::ip_t     src_ip,
    input  wire arp_pkg::mac_t    src_mac,
    input  wire arp_pkg::ip_t     dst_ip,
    input  wire arp_pkg::ip_t     query_ip,
    // Result transfer.
    output logic                  done,
    output logic                  found,
    output arp_pkg::mac_t         found_mac,
    output logic                  learned,
    output logic                  table_full,
    output logic                  send_reply,
    output arp_pkg::ip_t          reply_ip,
    output arp_pkg::mac_t         reply_mac,
    // Configuration transfer: own IP address.
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire arp_pkg::ip_t     cfg_data
);

    import arp_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t             state_reg, state_next;
    ip_t                own_ip_reg, own_ip_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // Item held during the scan.
    logic               lookup_reg, lookup_next;
    ip_t                key_ip_reg, key_ip_next;
    mac_t               key_mac_reg, key_mac_next;
    logic               reply_reg, reply_next;

    // Read issue stage.
    logic [CNT_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic               iss_en;
    logic [IDX_W-1:0]   iss_idx;

    // Compare stage, aligned with the memory read data.
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_ev_reg, cmp_ev_next;
    logic               cmp_last_reg, cmp_last_next;
    logic               cmp_hit;

    // Result registers.
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    mac_t               found_mac_reg, found_mac_next;
    logic               learned_reg, learned_next;
    logic               full_reg, full_next;
    logic               send_reg, send_next;
    ip_t                rip_reg, rip_next;
    mac_t               rmac_reg, rmac_next;

    // Entry memory.
    entry_t             mem [ENTRIES];
    entry_t             rd_data_reg;
    logic               wr_en;
    entry_t             wr_data;

    logic               accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    assign iss_en  = (state_reg == ST_SCAN) && (iss_cnt_reg != CNT_END);
    assign iss_idx = iss_cnt_reg[IDX_W-1:0];

    // A lookup needs a valid slot with the key; learning takes an empty slot
    // or one that already holds the sender IP.
    always_comb
    begin
        if (lookup_reg)
        begin
            cmp_hit = cmp_ev_reg && (rd_data_reg.ip == key_ip_reg);
        end
        else
        begin
            cmp_hit = !cmp_ev_reg || (rd_data_reg.ip == key_ip_reg);
        end
    end

    assign wr_data.ip  = key_ip_reg;
    assign wr_data.mac = key_mac_reg;

    always_comb
    begin
        state_next     = state_reg;
        own_ip_next    = own_ip_reg;
        valid_next     = valid_reg;
        lookup_next    = lookup_reg;
        key_ip_next    = key_ip_reg;
        key_mac_next   = key_mac_reg;
        reply_next     = reply_reg;
        iss_cnt_next   = iss_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        cmp_ev_next    = cmp_ev_reg;
        cmp_last_next  = cmp_last_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        found_mac_next = found_mac_reg;
        learned_next   = learned_reg;
        full_next      = full_reg;
        send_next      = send_reg;
        rip_next       = rip_reg;
        rmac_next      = rmac_reg;
        wr_en          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            own_ip_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lookup_next  = (action == ACT_LOOKUP);
                    key_ip_next  = (action == ACT_LOOKUP) ? query_ip : src_ip;
                    key_mac_next = src_mac;
                    reply_next   = (arp_operation == OP_REQUEST) &&
                                   (dst_ip == own_ip_reg);
                    iss_cnt_next = '0;
                    if ((action == ACT_PACKET) && (packet_length < MIN_ARP_LEN))
                    begin
                        // Short packet: nothing changes, all-zero result.
                        done_next      = 1'b1;
                        found_next     = 1'b0;
                        found_mac_next = '0;
                        learned_next   = 1'b0;
                        full_next      = 1'b0;
                        send_next      = 1'b0;
                        rip_next       = '0;
                        rmac_next      = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (iss_en)
                begin
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = iss_idx;
                    cmp_ev_next   = valid_reg[iss_idx];
                    cmp_last_next = (iss_idx == IDX_LAST);
                end

                if (cmp_vld_reg && (cmp_hit || cmp_last_reg))
                begin
                    state_next     = ST_IDLE;
                    cmp_vld_next   = 1'b0;
                    done_next      = 1'b1;
                    found_next     = 1'b0;
                    found_mac_next = '0;
                    learned_next   = 1'b0;
                    full_next      = 1'b0;
                    send_next      = 1'b0;
                    rip_next       = '0;
                    rmac_next      = '0;
                    if (lookup_reg)
                    begin
                        if (cmp_hit)
                        begin
                            found_next     = 1'b1;
                            found_mac_next = rd_data_reg.mac;
                        end
                    end
                    else
                    begin
                        if (cmp_hit)
                        begin
                            wr_en                   = 1'b1;
                            valid_next[cmp_idx_reg] = 1'b1;
                            learned_next            = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                        if (reply_reg)
                        begin
                            send_next = 1'b1;
                            rip_next  = key_ip_reg;
                            rmac_next = key_mac_reg;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            own_ip_reg  <= '0;
            valid_reg   <= '0;
            iss_cnt_reg <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            own_ip_reg  <= own_ip_next;
            valid_reg   <= valid_next;
            iss_cnt_reg <= iss_cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lookup_reg    <= lookup_next;
        key_ip_reg    <= key_ip_next;
        key_mac_reg   <= key_mac_next;
        reply_reg     <= reply_next;
        cmp_idx_reg   <= cmp_idx_next;
        cmp_ev_reg    <= cmp_ev_next;
        cmp_last_reg  <= cmp_last_next;
        found_reg     <= found_next;
        found_mac_reg <= found_mac_next;
        learned_reg   <= learned_next;
        full_reg      <= full_next;
        send_reg      <= send_next;
        rip_reg       <= rip_next;
        rmac_reg      <= rmac_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cmp_idx_reg] <= wr_data;
        end
        if (iss_en)
        begin
            rd_data_reg <= mem[iss_idx];
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign found_mac  = found_mac_reg;
    assign learned    = learned_reg;
    assign table_full = full_reg;
    assign send_reply = send_reg;
    assign reply_ip   = rip_reg;
    assign reply_mac  = rmac_reg;

    // An accepted item is either being scanned or answered in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted item neither scanned nor answered");

    // A result never mixes lookup fields with packet fields.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && (learned || table_full || send_reply)))
        else $error("lookup and packet results mixed");

    // A pair is either learned or rejected as table full, never both.
    a_learn_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(learned && table_full))
        else $error("learned and table_full both set");

    // The memory is written only for a packet that ends its scan.
    a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_SCAN) && !lookup_reg && cmp_vld_reg))
        else $error("entry memory written outside a packet scan");

endmodule

`default_nettype wire
